// ===== rtl/mei_pkg.sv =====
// Shared constants and types for the Mandelbrot escape-time unit.
`timescale 1ns / 1ps
package mei_pkg;
    localparam int TAG_W      = 11;
    localparam int CFG_W      = 16;
    localparam int C_W        = 32;
    localparam int Z_W        = 64;
    localparam int FRAC       = 28;
    localparam int MAG_FRAC   = 24;
    localparam int MAG_W      = 48;
    localparam int CFG_RESET  = 50;
    localparam logic [Z_W-1:0]   COMP_LIM = 64'h4000_0000_0000_0000;
    localparam logic [Z_W-1:0]   ESC_LIM  = 64'(4) << FRAC;
    localparam logic [MAG_W-1:0] MAG_MAX  = '1;

    typedef struct packed {
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
        logic [TAG_W-1:0]      x;
        logic [TAG_W-1:0]      y;
        logic                  skip;
    } t_job;

    typedef struct packed {
        logic [TAG_W-1:0] x;
        logic [TAG_W-1:0] y;
        logic             esc;
        logic [CFG_W-1:0] steps;
        logic [MAG_W-1:0] mag;
    } t_res;

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_OUT} t_state;
    typedef enum logic [1:0] {PH_LOOP, PH_EXTRA, PH_FINAL} t_phase;
endpackage

// ===== rtl/mei_front.sv =====
// Front end: accepts points, marks one-step budgets and queues them for the core.
`timescale 1ns / 1ps
module mei_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [mei_pkg::C_W-1:0] i_c_real,
    input  logic signed [mei_pkg::C_W-1:0] i_c_imag,
    input  logic [mei_pkg::TAG_W-1:0]   i_pixel_x,
    input  logic [mei_pkg::TAG_W-1:0]   i_pixel_y,
    input  logic [mei_pkg::CFG_W-1:0]   i_max_iter,
    output logic                        o_job_valid,
    output mei_pkg::t_job               o_job,
    input  logic                        i_job_pop
);
    import mei_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign full        = (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign wr          = push && !full;
    assign rd          = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{cr: i_c_real, ci: i_c_imag, x: i_pixel_x, y: i_pixel_y,
                           skip: (i_max_iter == CFG_W'(1))};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
endmodule

// ===== rtl/mei_mul.sv =====
// Saturating fixed-point multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
module mei_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_dbl,
    input  logic signed [mei_pkg::Z_W-1:0] i_x,
    input  logic signed [mei_pkg::Z_W-1:0] i_y,
    output logic                           o_done,
    output logic signed [mei_pkg::Z_W-1:0] o_res
);
    import mei_pkg::*;

    logic [Z_W-1:0]   r_ux, r_uy;
    logic             r_neg, r_dbl, r_busy, r_fin, r_done;
    logic [1:0]       r_cnt;
    logic [2*Z_W-1:0] r_acc;
    logic [Z_W-1:0]   r_res;
    logic [31:0]      op_x, op_y;
    logic [63:0]      pp;
    logic [2*Z_W-1:0] pp_sh, q;
    logic             sat;
    logic [Z_W-1:0]   mag;

    assign op_x = r_cnt[1] ? r_ux[63:32] : r_ux[31:0];
    assign op_y = r_cnt[0] ? r_uy[63:32] : r_uy[31:0];
    assign pp   = op_x * op_y;

    always_comb begin
        case ({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]})
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        q   = r_dbl ? (r_acc >> (FRAC - 1)) : (r_acc >> FRAC);
        sat = (|q[2*Z_W-1:63]) || (q[62] && (|q[61:0]));
        mag = sat ? COMP_LIM : q[Z_W-1:0];
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ux  <= i_x[Z_W-1] ? -i_x : i_x;
            r_uy  <= i_y[Z_W-1] ? -i_y : i_y;
            r_neg <= i_x[Z_W-1] ^ i_y[Z_W-1];
            r_dbl <= i_dbl;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_fin) r_res <= r_neg ? -mag : mag;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && (r_cnt == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) r_busy <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/mei_core.sv =====
// Back end: iterates one point at a time and holds the finished result item.
`timescale 1ns / 1ps
module mei_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mei_pkg::CFG_W-1:0] i_max_iter,
    input  logic                      i_job_valid,
    input  mei_pkg::t_job             i_job,
    output logic                      o_job_pop,
    output logic                      o_res_valid,
    output mei_pkg::t_res             o_res,
    input  logic                      i_res_pop
);
    import mei_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase;
    logic signed [Z_W-1:0] r_a, r_b, aa, bb, ab;
    logic signed [C_W-1:0] r_cr, r_ci;
    logic [CFG_W-1:0]      r_rem, rem_dec;
    logic                  r_first, r_out_valid;
    t_res                  r_pend, r_res;
    logic                  mul_start, done, done_b, done_c;
    logic [Z_W-1:0]        mag;
    logic [MAG_W-1:0]      mag_out;
    logic signed [Z_W+1:0] sa, sb;
    logic signed [Z_W-1:0] na, nb;
    logic                  slot_free, escape;

    mei_mul u_aa (.i_clk, .i_rst_n, .i_start(mul_start), .i_dbl(1'b0),
                  .i_x(r_a), .i_y(r_a), .o_done(done), .o_res(aa));
    mei_mul u_bb (.i_clk, .i_rst_n, .i_start(mul_start), .i_dbl(1'b0),
                  .i_x(r_b), .i_y(r_b), .o_done(done_b), .o_res(bb));
    mei_mul u_ab (.i_clk, .i_rst_n, .i_start(mul_start), .i_dbl(1'b1),
                  .i_x(r_a), .i_y(r_b), .o_done(done_c), .o_res(ab));

    always_comb begin
        mag     = aa + bb;
        sa      = (Z_W+2)'(aa) - (Z_W+2)'(bb) + (Z_W+2)'(r_cr);
        sb      = (Z_W+2)'(ab) + (Z_W+2)'(r_ci);
        na      = (sa > $signed({2'b00, COMP_LIM})) ? $signed(COMP_LIM) :
                  (sa < -$signed({2'b00, COMP_LIM})) ? -$signed(COMP_LIM) : sa[Z_W-1:0];
        nb      = (sb > $signed({2'b00, COMP_LIM})) ? $signed(COMP_LIM) :
                  (sb < -$signed({2'b00, COMP_LIM})) ? -$signed(COMP_LIM) : sb[Z_W-1:0];
        rem_dec = r_rem - CFG_W'(1);
        escape  = !r_first && (mag > ESC_LIM);
        mag_out = ((mag >> (FRAC - MAG_FRAC)) > Z_W'(MAG_MAX)) ? MAG_MAX :
                  MAG_W'(mag >> (FRAC - MAG_FRAC));
    end

    assign slot_free = !r_out_valid || i_res_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_job_valid) n_state = i_job.skip ? ST_OUT : ST_START;
            ST_START: n_state = ST_WAIT;
            ST_WAIT: begin
                if (done && done_b && done_c) begin
                    if (r_phase == PH_FINAL) n_state = ST_OUT;
                    else if (r_phase == PH_LOOP && !escape && rem_dec == '0)
                        n_state = ST_OUT;
                    else n_state = ST_START;
                end
            end
            ST_OUT:   if (slot_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_start = (r_state == ST_START);
        o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_a     <= Z_W'(i_job.cr);
            r_b     <= Z_W'(i_job.ci);
            r_cr    <= i_job.cr;
            r_ci    <= i_job.ci;
            r_rem   <= i_max_iter;
            r_first <= 1'b1;
            r_phase <= PH_LOOP;
            r_pend  <= '{x: i_job.x, y: i_job.y, esc: 1'b0, steps: '0, mag: '0};
        end else if (r_state == ST_WAIT && done) begin
            case (r_phase)
                PH_LOOP: begin
                    if (escape) begin
                        r_a     <= na;
                        r_b     <= nb;
                        r_phase <= PH_EXTRA;
                        r_pend.esc   <= 1'b1;
                        r_pend.steps <= i_max_iter - r_rem;
                    end else if (rem_dec != '0) begin
                        r_a     <= na;
                        r_b     <= nb;
                        r_rem   <= rem_dec;
                        r_first <= 1'b0;
                    end
                end
                PH_EXTRA: begin
                    r_a     <= na;
                    r_b     <= nb;
                    r_phase <= PH_FINAL;
                end
                default: r_pend.mag <= mag_out;
            endcase
        end
        if (r_state == ST_OUT && slot_free) r_res <= r_pend;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && slot_free) r_out_valid <= 1'b1;
            else if (i_res_pop) r_out_valid <= 1'b0;
        end
    end
endmodule

// ===== rtl/mandelbrot_escape_iteration.sv =====
// Top level of the Mandelbrot escape-time unit.
// Each point c (signed Q4.28) is iterated z = z*z + c from z = c, at most max_iterations-1
// steps, stopping once |z|^2 exceeds 4; an escaped point gets two extra steps and reports
// its step count and saturated |z|^2 in Q24.24. Each iteration pass runs three multipliers
// that each build a product from four 32x32 partial products. Two items queue at the
// input and one result waits at the output.
`timescale 1ns / 1ps
module mandelbrot_escape_iteration (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mei_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  logic                           push,
    output logic                           full,
    input  logic signed [mei_pkg::C_W-1:0] i_c_real,
    input  logic signed [mei_pkg::C_W-1:0] i_c_imag,
    input  logic [mei_pkg::TAG_W-1:0]      i_pixel_x,
    input  logic [mei_pkg::TAG_W-1:0]      i_pixel_y,
    output logic                           empty,
    input  logic                           pop,
    output logic [mei_pkg::TAG_W-1:0]      o_out_x,
    output logic [mei_pkg::TAG_W-1:0]      o_out_y,
    output logic                           o_escaped,
    output logic [mei_pkg::CFG_W-1:0]      o_steps_taken,
    output logic [mei_pkg::MAG_W-1:0]      o_final_mag_sq
);
    import mei_pkg::*;

    logic [CFG_W-1:0] r_max_iter;
    logic             job_valid, job_pop, res_valid;
    t_job             job;
    t_res             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_iter <= CFG_W'(CFG_RESET);
        else if (i_cfg_wr_en) r_max_iter <= i_cfg_wr_data;
    end

    mei_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_c_real, .i_c_imag, .i_pixel_x, .i_pixel_y,
        .i_max_iter(r_max_iter), .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    mei_core u_core (
        .i_clk, .i_rst_n, .i_max_iter(r_max_iter), .i_job_valid(job_valid), .i_job(job),
        .o_job_pop(job_pop), .o_res_valid(res_valid), .o_res(res), .i_res_pop(pop)
    );

    assign empty          = !res_valid;
    assign o_out_x        = res.x;
    assign o_out_y        = res.y;
    assign o_escaped      = res.esc;
    assign o_steps_taken  = res.steps;
    assign o_final_mag_sq = res.mag;
endmodule

// ===== dv/tb_mandelbrot_escape_iteration.sv =====
// Self-checking testbench for the Mandelbrot escape-time unit with its own escape predictor.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_iteration;
    import mei_pkg::*;

    localparam longint CYCLE_LIMIT = 20000000;
    localparam logic [31:0] ONE = 32'h1000_0000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_W-1:0]        i_cfg_wr_data;
    logic                    push;
    logic                    full;
    logic signed [C_W-1:0]   i_c_real;
    logic signed [C_W-1:0]   i_c_imag;
    logic [TAG_W-1:0]        i_pixel_x;
    logic [TAG_W-1:0]        i_pixel_y;
    logic                    empty;
    logic                    pop;
    logic [TAG_W-1:0]        o_out_x;
    logic [TAG_W-1:0]        o_out_y;
    logic                    o_escaped;
    logic [CFG_W-1:0]        o_steps_taken;
    logic [MAG_W-1:0]        o_final_mag_sq;

    t_res             pixel_results[$];
    logic [CFG_W-1:0] budget;
    int               errors;
    longint           cycles;
    int               burst_left;
    bit               no_gaps;
    bit               pop_always;
    int               hold_req;
    int               hold_cnt;

    mandelbrot_escape_iteration dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .push(push), .full(full),
        .i_c_real(i_c_real), .i_c_imag(i_c_imag),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .empty(empty), .pop(pop),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_escaped(o_escaped),
        .o_steps_taken(o_steps_taken), .o_final_mag_sq(o_final_mag_sq)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_comp(longint v);
        longint lim;
        lim = longint'(COMP_LIM);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint mul_trunc(longint x, longint y, int s);
        logic [63:0]  ux;
        logic [63:0]  uy;
        logic [127:0] r;
        bit           neg;
        neg = (x < 0) != (y < 0);
        ux = (x < 0) ? 64'(-x) : 64'(x);
        uy = (y < 0) ? 64'(-y) : 64'(y);
        r = ({64'd0, ux} * {64'd0, uy}) >> s;
        if (r > {64'd0, COMP_LIM}) r = {64'd0, COMP_LIM};
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic logic [63:0] z_step(inout longint a, inout longint b,
                                           input longint cr, input longint ci);
        longint na;
        longint nb;
        na = clamp_comp(mul_trunc(a, a, FRAC) - mul_trunc(b, b, FRAC) + cr);
        nb = clamp_comp(mul_trunc(a, b, FRAC - 1) + ci);
        a = na;
        b = nb;
        return 64'(mul_trunc(na, na, FRAC)) + 64'(mul_trunc(nb, nb, FRAC));
    endfunction

    function automatic t_res predict_pixel(logic signed [C_W-1:0] cr, logic signed [C_W-1:0] ci,
                                           logic [TAG_W-1:0] x, logic [TAG_W-1:0] y,
                                           logic [CFG_W-1:0] iters);
        longint           a;
        longint           b;
        logic [CFG_W-1:0] left;
        logic [63:0]      mag;
        t_res             r;
        a = cr;
        b = ci;
        left = iters;
        mag = '0;
        while (1) begin
            left = left - 1'b1;
            if (left == 0) break;
            if (z_step(a, b, cr, ci) > ESC_LIM) break;
        end
        r = '0;
        r.x = x;
        r.y = y;
        if (left != 0) begin
            mag = z_step(a, b, cr, ci);
            mag = z_step(a, b, cr, ci);
            mag = mag >> (FRAC - MAG_FRAC);
            if (mag > {16'd0, MAG_MAX}) mag = {16'd0, MAG_MAX};
            r.esc = 1'b1;
            r.steps = iters - left;
            r.mag = mag[MAG_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls on its own pattern and honours long hold-offs.
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else if (pop_always) begin
            pop <= 1'b1;
        end else begin
            pop <= ((cycles % 13) < 9) && ($urandom_range(0, 4) != 0);
        end
    end

    always @(negedge i_clk) begin
        t_res want;
        if (i_rst_n && !empty && pop) begin
            if (pixel_results.size() == 0) begin
                report_mismatch("unexpected item", o_out_x, 0);
            end else begin
                want = pixel_results.pop_front();
                if (o_out_x !== want.x) report_mismatch("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) report_mismatch("out_y", o_out_y, want.y);
                if (o_escaped !== want.esc) report_mismatch("escaped", o_escaped, want.esc);
                if (o_steps_taken !== want.steps)
                    report_mismatch("steps_taken", o_steps_taken, want.steps);
                if (o_final_mag_sq !== want.mag)
                    report_mismatch("final_mag_sq", o_final_mag_sq, want.mag);
            end
        end
    end

    task automatic send_pixel(logic [31:0] cr, logic [31:0] ci,
                              logic [TAG_W-1:0] x, logic [TAG_W-1:0] y);
        bit f;
        push <= 1'b1;
        i_c_real <= cr;
        i_c_imag <= ci;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do begin
            @(negedge i_clk);
            f = full;
            @(posedge i_clk);
        end while (f);
        pixel_results.push_back(predict_pixel(cr, ci, x, y, budget));
        if (!no_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic drain;
        push <= 1'b0;
        while (pixel_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_budget(logic [CFG_W-1:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        budget = v;
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return 32'($signed($urandom_range(0, 32'h4800_0000)) - 32'sh2400_0000);
    endfunction

    task automatic test_directed_points;
        send_pixel(32'd0, 32'd0, 11'd0, 11'd0);
        send_pixel(-ONE, 32'd0, 11'd2047, 11'd2047);
        send_pixel(2 * ONE, 32'd0, 11'd1, 11'd2);
        send_pixel(-2 * ONE, 32'd0, 11'd3, 11'd4);
        send_pixel(ONE, 32'd0, 11'd5, 11'd6);
        send_pixel(32'd0, ONE, 11'd7, 11'd8);
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 11'h555, 11'h2AA);
        send_pixel(32'h8000_0000, 32'h8000_0000, 11'h2AA, 11'h555);
        send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 11'd9, 11'd10);
        send_pixel(32'hF400_0000, 32'h0199_999A, 11'd11, 11'd12);
        send_pixel(32'h0400_0000, 32'h0800_0000, 11'd13, 11'd14);
        send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 11'd15, 11'd16);
    endtask

    task automatic test_budget_extremes;
        set_budget(16'd2);
        send_pixel(32'd0, 32'd0, 11'd20, 11'd21);
        send_pixel(2 * ONE, ONE, 11'd22, 11'd23);
        set_budget(16'd1);
        send_pixel(2 * ONE, ONE, 11'd24, 11'd25);
        send_pixel(32'd0, 32'd0, 11'd26, 11'd27);
        set_budget(16'd0);
        send_pixel(2 * ONE, 32'd0, 11'd28, 11'd29);
        send_pixel(32'h0600_0000, 32'h0800_0000, 11'd30, 11'd31);
        set_budget(16'hFFFF);
        send_pixel(32'h0600_0000, 32'h0800_0000, 11'd32, 11'd33);
        send_pixel(-ONE, 32'd0, 11'd34, 11'd35);
    endtask

    task automatic test_backpressure;
        set_budget(16'd50);
        no_gaps = 1'b1;
        hold_req = 600;
        repeat (12) send_pixel(2 * ONE + $urandom_range(0, 255), ONE,
                               TAG_W'($urandom()), TAG_W'($urandom()));
        no_gaps = 1'b0;
    endtask

    task automatic test_random_points(logic [CFG_W-1:0] iters, int n, bit steady);
        set_budget(iters);
        pop_always = steady;
        repeat (n) send_pixel(rand_coord(), rand_coord(),
                              TAG_W'($urandom()), TAG_W'($urandom()));
        pop_always = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        push = 1'b0;
        pop = 1'b0;
        i_c_real = '0;
        i_c_imag = '0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        budget = 16'(CFG_RESET);
        errors = 0;
        cycles = 0;
        burst_left = 4;
        no_gaps = 1'b0;
        pop_always = 1'b0;
        hold_req = 0;
        hold_cnt = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_points();
        test_budget_extremes();
        test_backpressure();
        test_random_points(16'd50, 350, 1'b0);
        test_random_points(16'd2, 150, 1'b1);
        test_random_points(16'd13, 200, 1'b0);
        test_random_points(16'd120, 200, 1'b0);
        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
